[rtl/core/arh_pkg.sv]
// Shared constants, types and helper functions of the auto-ranging histogram.
package arh_pkg;

  localparam int MAX_BANDS  = 128;
  localparam int FRAC_BITS  = 16;
  localparam int EDGE_SLOTS = MAX_BANDS + 1;
  localparam int SLOT_W     = $clog2(EDGE_SLOTS);
  localparam int CNT_W      = $clog2(MAX_BANDS + 1);
  localparam int POS_W      = 7;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_BWIDTH = 2'd1;
  localparam logic [1:0] REG_GROWTH = 2'd2;
  localparam logic [1:0] REG_TOL    = 2'd3;

  localparam logic MODE_LOG = 1'b1;
  localparam logic OP_READ  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic load;
    logic mul;
    logic mul_up;
    logic down_wr;
    logic up_wr;
    logic scan_prime;
    logic scan;
    logic result;
  } arh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic restart;
    logic init_last;
    logic is_read;
    logic down_go;
    logic down_ok;
    logic up_go;
    logic up_ok;
    logic bad_idx;
    logic match;
    logic scan_end;
    logic out_free;
  } arh_sts_t;

  // Step a ring slot forwards with wrap.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(EDGE_SLOTS - 1)) r = '0;
    else r = s + SLOT_W'(1);
    return r;
  endfunction

  // Step a ring slot backwards with wrap.
  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == '0) r = SLOT_W'(EDGE_SLOTS - 1);
    else r = s - SLOT_W'(1);
    return r;
  endfunction

  // Ring slot of a position counted from the front slot.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] f,
                                                 input logic [CNT_W-1:0]  p);
    logic [SLOT_W:0] s;
    s = {1'b0, f} + (SLOT_W + 1)'(p);
    if (s >= (SLOT_W + 1)'(EDGE_SLOTS)) s = s - (SLOT_W + 1)'(EDGE_SLOTS);
    return s[SLOT_W-1:0];
  endfunction

  // Saturate a 34-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/core/arh_ctrl.sv]
// Controller state machine that sequences layout build, expansion, band scan and result.
module arh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  arh_pkg::arh_sts_t sts,
  output arh_pkg::arh_cmd_t cmd
);
  import arh_pkg::*;

  typedef enum logic [10:0] {
    S_INIT   = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_DCHK   = 11'b000_0000_0100,
    S_DMUL   = 11'b000_0000_1000,
    S_DWR    = 11'b000_0001_0000,
    S_UCHK   = 11'b000_0010_0000,
    S_UMUL   = 11'b000_0100_0000,
    S_UWR    = 11'b000_1000_0000,
    S_SPRIME = 11'b001_0000_0000,
    S_SCAN   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DCHK;
        end
      end
      S_DCHK: begin
        if (sts.is_read) state_nxt = S_SPRIME;
        else if (sts.down_go) state_nxt = S_DMUL;
        else state_nxt = S_UCHK;
      end
      S_DMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DWR;
      end
      S_DWR: begin
        if (sts.down_ok) begin
          cmd.down_wr = 1'b1;
          state_nxt   = S_DCHK;
        end else begin
          state_nxt = S_UCHK;
        end
      end
      S_UCHK: begin
        if (sts.up_go) state_nxt = S_UMUL;
        else state_nxt = S_SPRIME;
      end
      S_UMUL: begin
        cmd.mul    = 1'b1;
        cmd.mul_up = 1'b1;
        state_nxt  = S_UWR;
      end
      S_UWR: begin
        if (sts.up_ok) begin
          cmd.up_wr = 1'b1;
          state_nxt = S_UCHK;
        end else begin
          state_nxt = S_SPRIME;
        end
      end
      S_SPRIME: begin
        cmd.scan_prime = 1'b1;
        if (sts.bad_idx) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match || sts.scan_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    // A layout register write rebuilds the histogram.
    if (sts.restart) state_nxt = S_INIT;
  end

endmodule

[rtl/core/arh_datapath.sv]
// Datapath: configuration, band edge and hit stores, arithmetic and result register.
module arh_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  arh_pkg::arh_cmd_t cmd,
  output arh_pkg::arh_sts_t sts,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_tuser,
  input  logic [55:0]       in_tdata,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic              out_tuser,
  output logic [255:0]      out_tdata
);
  import arh_pkg::*;

  localparam int PROD_W = 53;
  localparam int RMAG_W = PROD_W + 1 - FRAC_BITS;

  // Configuration registers.
  logic        mode_r;
  logic [30:0] bw_r;
  logic [20:0] growth_r;
  logic [15:0] tol_r;

  // Accepted item.
  logic               op_r;
  logic signed [31:0] val_r;
  logic [15:0]        wgt_r;
  logic [6:0]         idx_r;

  // Layout.
  logic [SLOT_W-1:0]  front_r, back_r;
  logic [CNT_W-1:0]   used_r;
  logic signed [31:0] left_r, right_r;
  logic [1:0]         init_cnt_r;
  logic [PROD_W-1:0]  prod_r;

  // Scan and result.
  logic [CNT_W-1:0]   pos_r;
  logic [SLOT_W-1:0]  lo_slot_r;
  logic               res_found_r;
  logic [POS_W-1:0]   res_pos_r;
  logic signed [31:0] res_lo_r, res_hi_r;
  logic [31:0]        res_hits_r;

  // Statistics.
  logic [31:0]        vcnt_r;
  logic signed [31:0] min_r, max_r;
  logic signed [47:0] sum_r;

  // Stores.
  logic signed [31:0] edge_mem [EDGE_SLOTS];
  logic [31:0]        hit_mem  [EDGE_SLOTS];
  logic signed [31:0] edge_lo_q, edge_hi_q;
  logic [31:0]        hit_q;

  logic               out_valid_r;
  logic [254:0]       out_data_r;
  logic               out_found_r;

  // Combinational values.
  logic signed [33:0] v34, tol34, bw34, left34, right34;
  logic signed [31:0] neg_bw;
  logic               is_log;
  logic [31:0]        mag;
  logic [PROD_W:0]    rsum;
  logic [RMAG_W-1:0]  rmag;
  logic [32:0]        rcl;
  logic signed [31:0] nl, nr;
  logic [CNT_W-1:0]   start_pos;
  logic [SLOT_W-1:0]  rd_slot;
  logic               in_band;
  logic [32:0]        hit_sum;
  logic [31:0]        hit_new;
  logic               e_we, h_we;
  logic [SLOT_W-1:0]  e_wa, h_wa;
  logic signed [31:0] e_wd, init_edge;
  logic [31:0]        h_wd;
  logic signed [48:0] sum49;
  logic signed [47:0] sum_sat;
  logic [31:0]        in_val;

  assign is_log  = (mode_r == MODE_LOG);
  assign v34     = 34'(val_r);
  assign tol34   = 34'(tol_r);
  assign bw34    = 34'(bw_r);
  assign left34  = 34'(left_r);
  assign right34 = 34'(right_r);
  assign neg_bw  = -32'($signed({1'b0, bw_r}));
  assign in_val  = in_tdata[31:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      bw_r     <= 31'd65536;
      growth_r <= 21'd131072;
      tol_r    <= 16'd66;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[0];
        REG_BWIDTH: bw_r     <= cfg_data[30:0];
        REG_GROWTH: growth_r <= cfg_data[20:0];
        REG_TOL:    tol_r    <= cfg_data[15:0];
        default:    mode_r   <= mode_r;
      endcase
    end
  end

  assign sts.restart = cfg_valid && (cfg_index == REG_MODE || cfg_index == REG_BWIDTH);

  // Multiply the outer edge magnitude by growth.
  assign mag = (cmd.mul_up ? right_r[31] : left_r[31]) ?
               32'(-(cmd.mul_up ? right34 : left34)) :
               32'(cmd.mul_up ? right_r : left_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= PROD_W'(mag) * PROD_W'(growth_r);
  end

  // Round the product up and clamp to the edge range; in linear mode the new edges step by band width.
  always_comb begin
    rsum = {1'b0, prod_r} + (PROD_W + 1)'((2 ** FRAC_BITS) - 1);
    rmag = rsum[PROD_W:FRAC_BITS];
    if (rmag > RMAG_W'(33'h1_0000_0000 >> 1)) rcl = 33'h0_8000_0000;
    else rcl = 33'(rmag);
    if (is_log) begin
      nl = sat32(-34'($signed({1'b0, rcl})));
      nr = sat32(34'($signed({1'b0, rcl})));
    end else begin
      nl = sat32(left34 - bw34);
      nr = sat32(right34 + bw34);
    end
  end

  // Expansion decisions.
  assign sts.down_go = !(v34 > left34 - tol34) && !(is_log && !val_r[31]) &&
                       (used_r < CNT_W'(MAX_BANDS));
  assign sts.up_go   = !(v34 < right34 + tol34) && !(is_log && val_r[31]) &&
                       (used_r < CNT_W'(MAX_BANDS));
  assign sts.down_ok = nl < left_r;
  assign sts.up_ok   = nr > right_r;
  assign sts.is_read = (op_r == OP_READ);
  assign sts.init_last = (init_cnt_r == 2'd2);

  // Scan addressing and band test.
  assign start_pos   = (op_r == OP_READ) ? CNT_W'(idx_r) : '0;
  assign rd_slot     = cmd.scan_prime ? slot_add(front_r, start_pos) : slot_inc(lo_slot_r);
  assign sts.bad_idx = (op_r == OP_READ) && (CNT_W'(idx_r) >= used_r);
  assign in_band     = (v34 > 34'(edge_lo_q) - tol34) && (v34 < 34'(edge_hi_q) + tol34);
  assign sts.match   = (op_r == OP_READ) || in_band;
  assign sts.scan_end = ((pos_r + CNT_W'(1)) >= used_r);
  assign hit_sum     = {1'b0, hit_q} + 33'(wgt_r);
  assign hit_new     = hit_sum[32] ? 32'hFFFF_FFFF : hit_sum[31:0];

  // Initial layout edges.
  always_comb begin
    case (init_cnt_r)
      2'd0:    init_edge = is_log ? neg_bw : 32'sd0;
      2'd1:    init_edge = is_log ? 32'sd0 : 32'($signed({1'b0, bw_r}));
      default: init_edge = is_log ? 32'($signed({1'b0, bw_r})) : 32'sd0;
    endcase
  end

  // Store write selection.
  always_comb begin
    e_we = 1'b0; e_wa = '0; e_wd = '0;
    h_we = 1'b0; h_wa = '0; h_wd = '0;
    if (cmd.init) begin
      e_we = 1'b1; e_wa = SLOT_W'(init_cnt_r); e_wd = init_edge;
      h_we = 1'b1; h_wa = SLOT_W'(init_cnt_r);
    end else if (cmd.down_wr) begin
      e_we = 1'b1; e_wa = slot_dec(front_r); e_wd = nl;
      h_we = 1'b1; h_wa = slot_dec(front_r);
    end else if (cmd.up_wr) begin
      e_we = 1'b1; e_wa = slot_inc(back_r); e_wd = nr;
      h_we = 1'b1; h_wa = back_r;
    end else if (cmd.scan && in_band && op_r != OP_READ) begin
      h_we = 1'b1; h_wa = lo_slot_r; h_wd = hit_new;
    end
  end

  // Edge and hit stores, read data registered.
  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    edge_lo_q <= edge_mem[rd_slot];
    edge_hi_q <= edge_mem[slot_inc(rd_slot)];
  end

  always_ff @(posedge clk) begin
    if (h_we) hit_mem[h_wa] <= h_wd;
    hit_q <= hit_mem[rd_slot];
  end

  // Init counter.
  always_ff @(posedge clk) begin
    if (!rst_n || sts.restart) init_cnt_r <= '0;
    else if (cmd.init && !sts.init_last) init_cnt_r <= init_cnt_r + 2'd1;
  end

  // Layout registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      used_r  <= '0;
    end else if (cmd.init) begin
      front_r <= '0;
      back_r  <= is_log ? SLOT_W'(2) : SLOT_W'(1);
      used_r  <= is_log ? CNT_W'(2) : CNT_W'(1);
    end else if (cmd.down_wr) begin
      front_r <= slot_dec(front_r);
      used_r  <= used_r + CNT_W'(1);
    end else if (cmd.up_wr) begin
      back_r  <= slot_inc(back_r);
      used_r  <= used_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      left_r  <= is_log ? neg_bw : 32'sd0;
      right_r <= 32'($signed({1'b0, bw_r}));
    end else if (cmd.down_wr) begin
      left_r <= nl;
    end else if (cmd.up_wr) begin
      right_r <= nr;
    end
  end

  // Item capture, scan progress and band result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_tuser;
      val_r       <= $signed(in_val);
      wgt_r       <= in_tdata[47:32];
      idx_r       <= in_tdata[54:48];
      res_found_r <= 1'b0;
      res_pos_r   <= (in_tuser == OP_READ) ? in_tdata[54:48] : '0;
      res_lo_r    <= '0;
      res_hi_r    <= '0;
      res_hits_r  <= '0;
    end
    if (cmd.scan_prime) begin
      pos_r     <= start_pos;
      lo_slot_r <= rd_slot;
    end else if (cmd.scan) begin
      if (sts.match) begin
        res_found_r <= 1'b1;
        res_pos_r   <= pos_r[POS_W-1:0];
        res_lo_r    <= edge_lo_q;
        res_hi_r    <= edge_hi_q;
        res_hits_r  <= (op_r == OP_READ) ? hit_q : hit_new;
      end else begin
        pos_r     <= pos_r + CNT_W'(1);
        lo_slot_r <= rd_slot;
      end
    end
  end

  // Running statistics, updated when an add beat is taken.
  always_comb begin
    sum49 = 49'(sum_r) + 49'($signed(in_val));
    if (sum49 > 49'sh0_7FFF_FFFF_FFFF) sum_sat = 48'sh7FFF_FFFF_FFFF;
    else if (sum49 < -49'sh0_8000_0000_0000) sum_sat = 48'sh8000_0000_0000;
    else sum_sat = sum49[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      vcnt_r <= '0;
      min_r  <= '0;
      max_r  <= '0;
      sum_r  <= '0;
    end else if (cmd.load && in_tuser != OP_READ) begin
      sum_r <= sum_sat;
      if (vcnt_r == '0 || $signed(in_val) < min_r) min_r <= $signed(in_val);
      if (vcnt_r == '0 || $signed(in_val) > max_r) max_r <= $signed(in_val);
      if (vcnt_r != 32'hFFFF_FFFF) vcnt_r <= vcnt_r + 32'd1;
    end
  end

  // Output register.
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.result) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_found_r <= res_found_r;
      out_data_r  <= {sum_r, max_r, min_r, vcnt_r, used_r, res_hits_r,
                      res_hi_r, res_lo_r, res_pos_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule

[rtl/core/auto_ranging_histogram.sv]
// An add expands the layout as needed and then scans the bands up to the hit before its
// result beat; a read goes straight to its band, and an index past the bands skips the scan.
// One item is in work at a time.
// The rate is set by the band scan, which reads one band per cycle from the edge store,
// and by expansion, which passes through a check, a multiply and a write state per new band.
// Reset is synchronous; after reset and after any mode or band_width write the block
// rebuilds the initial layout before it takes an item.
module auto_ranging_histogram (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,    // op
  input  logic [55:0]  in_tdata,    // value[31:0], weight[47:32], band_index[54:48]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tuser,   // band_found
  // band_position[6:0], band_low[38:7], band_high[70:39], band_hits[102:71],
  // band_count[110:103], value_count[142:111], min_value[174:143],
  // max_value[206:175], sum_of_values[254:207]
  output logic [255:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import arh_pkg::*;

  arh_cmd_t cmd;
  arh_sts_t sts;

  assign cfg_ready = 1'b1;

  arh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  arh_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/core/arh_checker.sv]
// Port-level checks of the auto-ranging histogram, bound to its top level.
module arh_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tuser,
  input logic [55:0]  in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic         out_tuser,
  input logic [255:0] out_tdata,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [1:0]   cfg_index,
  input logic [31:0]  cfg_data
);

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result beat dropped");

  // The band count never exceeds the store size.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[110:103] <= 8'd128) else $error("band count too large");

  // A found band has ordered edges.
  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> $signed(out_tdata[38:7]) <= $signed(out_tdata[70:39]))
    else $error("band edges out of order");

  // The minimum never lies above the maximum.
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[174:143]) <= $signed(out_tdata[206:175]))
    else $error("minimum above maximum");

endmodule

bind auto_ranging_histogram arh_checker u_arh_checker (.*);
